### rtl/trm_pkg.sv
`timescale 1ns / 1ps

package trm_pkg;

   // Field widths of the request, response and window register
   localparam int TOTAL_BITS  = 48;
   localparam int TIME_BITS   = 32;
   localparam int RATE_BITS   = 31;
   localparam int WINDOW_BITS = 16;

   // Significant bits of the byte count (at most TOTAL_BITS)
   localparam int COUNT_BITS = 48;

   // x*1000 = (x << 10) - (x << 4) - (x << 3)
   localparam int SCALE_SHIFT = 10;
   localparam int TRIM_HI     = 4;
   localparam int TRIM_LO     = 3;
   localparam int NUM_BITS    = COUNT_BITS + SCALE_SHIFT;

   // Divider: the bits above the quotient width decide saturation up front,
   // then one restoring step per quotient bit.
   localparam int DIV_BITS  = (NUM_BITS > RATE_BITS + 1) ? NUM_BITS : RATE_BITS + 1;
   localparam int HI_BITS   = DIV_BITS - RATE_BITS;
   localparam int CMP_BITS  = TIME_BITS + 2;
   localparam int DIV_STEPS = RATE_BITS;
   localparam int STEP_BITS = $clog2(DIV_STEPS + 1);

   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(500);
   localparam logic [RATE_BITS-1:0]   RATE_MAX     = '1;

   typedef enum logic [0:0] {
      CMD_SAMPLE  = 1'b0,
      CMD_RESTART = 1'b1
   } req_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_RATE_START,
      ST_RATE_WAIT,
      ST_AVG_PREP,
      ST_AVG_START,
      ST_AVG_WAIT,
      ST_EMIT
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic latch_in;
      logic do_restart;
      logic do_first;
      logic capture_rate;
      logic capture_avg;
      logic div_start;
      logic commit_rate;
      logic commit_avg;
      logic load_rsp;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic restart_req;
      logic running;
      logic update_ok;
      logic div_done;
   } dp_status_type;

endpackage

### rtl/trm_chan_if.sv
`timescale 1ns / 1ps

// Request channel: one progress sample or restart command
interface trm_req_if import trm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [TOTAL_BITS-1:0] total_bytes;
   logic [TIME_BITS-1:0]  now_ms;

   modport source (output valid, cmd, total_bytes, now_ms, input ready);
   modport sink   (input valid, cmd, total_bytes, now_ms, output ready);
endinterface

// Response channel: one result per request
interface trm_rsp_if import trm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [RATE_BITS-1:0] rate_now;
   logic                 rate_changed;
   logic [RATE_BITS-1:0] rate_average;

   modport source (output valid, rate_now, rate_changed, rate_average, input ready);
   modport sink   (input valid, rate_now, rate_changed, rate_average, output ready);
endinterface

### rtl/trm_div.sv
`timescale 1ns / 1ps

// Saturating divider: quot = min(floor(num/den), RATE_MAX), 0 when den is 0.
// Start cycle checks saturation, then DIV_STEPS restoring steps.
module trm_div import trm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_BITS-1:0]  num,
   input  logic [TIME_BITS-1:0] den,
   output logic                 done,
   output logic [RATE_BITS-1:0] quot
);

   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [TIME_BITS-1:0] rem_ff, rem_in;
   logic [RATE_BITS-1:0] quo_ff, quo_in;
   logic [TIME_BITS-1:0] den_ff, den_in;
   logic                 sat_ff, sat_in;
   logic                 zero_ff, zero_in;

   logic [HI_BITS-1:0]   num_hi;
   logic [TIME_BITS:0]   trial;
   logic                 fits;

   assign num_hi = num[DIV_BITS-1:RATE_BITS];

   // Trial subtract of the shifted partial remainder
   assign trial = {rem_ff, quo_ff[RATE_BITS-1]} - {1'b0, den_ff};
   assign fits  = !trial[TIME_BITS];

   // Next values
   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      sat_in  = sat_ff;
      zero_in = zero_ff;
      done_in = (cnt_ff == STEP_BITS'(1));
      if (start) begin
         cnt_in  = STEP_BITS'(DIV_STEPS);
         rem_in  = TIME_BITS'(num_hi);
         quo_in  = num[RATE_BITS-1:0];
         den_in  = den;
         sat_in  = CMP_BITS'(num_hi) >= CMP_BITS'(den);
         zero_in = (den == '0);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - STEP_BITS'(1);
         if (fits) begin
            rem_in = trial[TIME_BITS-1:0];
         end else begin
            rem_in = {rem_ff[TIME_BITS-2:0], quo_ff[RATE_BITS-1]};
         end
         quo_in = {quo_ff[RATE_BITS-2:0], fits};
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      sat_ff  <= sat_in;
      zero_ff <= zero_in;
   end

   assign done = done_ff;

   always_comb begin
      priority if (zero_ff) begin
         quot = '0;
      end else if (sat_ff) begin
         quot = RATE_MAX;
      end else begin
         quot = quo_ff;
      end
   end

`ifndef NO_ASSERTIONS
   a_done_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##(DIV_STEPS + 1) done_ff)
      else $error("divider done not on schedule");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (cnt_ff == '0))
      else $error("divider started while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (cnt_ff == '0) && !$past(start))
      else $error("divider done while steps remain");
`endif

endmodule

### rtl/trm_dp.sv
`timescale 1ns / 1ps

// Measurement state, window register, operand prep, divider and response registers
module trm_dp import trm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             dp_cmd,
   output dp_status_type          dp_status,
   input  logic                   csr_we,
   input  logic [WINDOW_BITS-1:0] csr_wdata,
   input  logic                   req_cmd,
   input  logic [TOTAL_BITS-1:0]  req_total_bytes,
   input  logic [TIME_BITS-1:0]   req_now_ms,
   output logic [RATE_BITS-1:0]   rsp_rate_now,
   output logic                   rsp_rate_changed,
   output logic [RATE_BITS-1:0]   rsp_rate_average
);

   logic [WINDOW_BITS-1:0] min_window_ff, min_window_in;
   logic                   running_ff, running_in;
   logic [COUNT_BITS-1:0]  start_count_ff, start_count_in;
   logic [TIME_BITS-1:0]   start_time_ff, start_time_in;
   logic [COUNT_BITS-1:0]  mark_count_ff, mark_count_in;
   logic [TIME_BITS-1:0]   mark_time_ff, mark_time_in;
   logic [RATE_BITS-1:0]   last_rate_ff, last_rate_in;
   logic [RATE_BITS-1:0]   avg_ff, avg_in;
   logic                   changed_ff, changed_in;

   req_cmd_type            in_cmd_ff, in_cmd_in;
   logic [COUNT_BITS-1:0]  in_count_ff, in_count_in;
   logic [TIME_BITS-1:0]   in_time_ff, in_time_in;
   logic [COUNT_BITS-1:0]  diff_ff, diff_in;
   logic [TIME_BITS-1:0]   elapsed_ff, elapsed_in;
   logic [RATE_BITS-1:0]   rsp_rate_ff, rsp_rate_in;
   logic                   rsp_changed_ff, rsp_changed_in;
   logic [RATE_BITS-1:0]   rsp_avg_ff, rsp_avg_in;

   logic [TIME_BITS-1:0]   elapsed_now;
   logic [NUM_BITS-1:0]    diff_ext;
   logic [NUM_BITS-1:0]    scaled;
   logic                   div_done;
   logic [RATE_BITS-1:0]   div_quot;

   // Update test against the last point
   assign elapsed_now = in_time_ff - mark_time_ff;

   assign dp_status.restart_req = (in_cmd_ff == CMD_RESTART);
   assign dp_status.running     = running_ff;
   assign dp_status.update_ok   = (in_count_ff > mark_count_ff) &&
                                  (elapsed_now > TIME_BITS'(min_window_ff));
   assign dp_status.div_done    = div_done;

   // Dividend: count difference times 1000
   assign diff_ext = NUM_BITS'(diff_ff);
   assign scaled   = (diff_ext << SCALE_SHIFT) - (diff_ext << TRIM_HI) - (diff_ext << TRIM_LO);

   trm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (dp_cmd.div_start),
      .num   (DIV_BITS'(scaled)),
      .den   (elapsed_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Measurement state next values
   always_comb begin
      min_window_in  = csr_we ? csr_wdata : min_window_ff;
      running_in     = running_ff;
      start_count_in = start_count_ff;
      start_time_in  = start_time_ff;
      mark_count_in  = mark_count_ff;
      mark_time_in   = mark_time_ff;
      last_rate_in   = last_rate_ff;
      avg_in         = avg_ff;
      changed_in     = changed_ff;
      if (dp_cmd.latch_in) begin
         changed_in = 1'b0;
      end
      if (dp_cmd.do_restart) begin
         running_in = 1'b0;
      end
      if (dp_cmd.do_first) begin
         running_in     = 1'b1;
         start_count_in = in_count_ff;
         start_time_in  = in_time_ff;
         mark_count_in  = in_count_ff;
         mark_time_in   = in_time_ff;
         last_rate_in   = '0;
         avg_in         = '0;
      end
      if (dp_cmd.commit_rate) begin
         mark_count_in = in_count_ff;
         mark_time_in  = in_time_ff;
         last_rate_in  = div_quot;
         changed_in    = (div_quot != last_rate_ff);
      end
      if (dp_cmd.commit_avg) begin
         avg_in = div_quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_window_ff  <= WINDOW_RESET;
         running_ff     <= 1'b0;
         start_count_ff <= '0;
         start_time_ff  <= '0;
         mark_count_ff  <= '0;
         mark_time_ff   <= '0;
         last_rate_ff   <= '0;
         avg_ff         <= '0;
         changed_ff     <= 1'b0;
      end else begin
         min_window_ff  <= min_window_in;
         running_ff     <= running_in;
         start_count_ff <= start_count_in;
         start_time_ff  <= start_time_in;
         mark_count_ff  <= mark_count_in;
         mark_time_ff   <= mark_time_in;
         last_rate_ff   <= last_rate_in;
         avg_ff         <= avg_in;
         changed_ff     <= changed_in;
      end
   end

   // Request capture, divider operands and response registers
   always_comb begin
      in_cmd_in      = in_cmd_ff;
      in_count_in    = in_count_ff;
      in_time_in     = in_time_ff;
      diff_in        = diff_ff;
      elapsed_in     = elapsed_ff;
      rsp_rate_in    = rsp_rate_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_avg_in     = rsp_avg_ff;
      if (dp_cmd.latch_in) begin
         in_cmd_in   = req_cmd_type'(req_cmd);
         in_count_in = req_total_bytes[COUNT_BITS-1:0];
         in_time_in  = req_now_ms;
      end
      priority if (dp_cmd.capture_rate) begin
         diff_in    = in_count_ff - mark_count_ff;
         elapsed_in = elapsed_now;
      end else if (dp_cmd.capture_avg) begin
         diff_in    = mark_count_ff - start_count_ff;
         elapsed_in = mark_time_ff - start_time_ff;
      end else begin
      end
      if (dp_cmd.load_rsp) begin
         rsp_rate_in    = last_rate_ff;
         rsp_changed_in = changed_ff;
         rsp_avg_in     = avg_ff;
      end
   end

   always_ff @(posedge clock) begin
      in_cmd_ff      <= in_cmd_in;
      in_count_ff    <= in_count_in;
      in_time_ff     <= in_time_in;
      diff_ff        <= diff_in;
      elapsed_ff     <= elapsed_in;
      rsp_rate_ff    <= rsp_rate_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_avg_ff     <= rsp_avg_in;
   end

   assign rsp_rate_now     = rsp_rate_ff;
   assign rsp_rate_changed = rsp_changed_ff;
   assign rsp_rate_average = rsp_avg_ff;

`ifndef NO_ASSERTIONS
   a_rate_moves_mark: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.commit_rate |=> (mark_time_ff == in_time_ff) && (mark_count_ff == in_count_ff))
      else $error("rate commit did not move the last point");
   a_first_clears: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.do_first |=> running_ff && (last_rate_ff == '0) && (avg_ff == '0))
      else $error("first sample did not clear rate and average");
   a_restart_keeps: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.do_restart |=> !running_ff && $stable(last_rate_ff) && $stable(mark_time_ff))
      else $error("restart changed measurement points");
`endif

endmodule

### rtl/trm_ctrl.sv
`timescale 1ns / 1ps

// Sequencer: takes one request, steps the datapath, hands off the response
module trm_ctrl import trm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    dp_cmd,
   input  dp_status_type dp_status
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   // Response register can take a new result
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            priority if (dp_status.restart_req) begin
               state_in = ST_EMIT;
            end else if (!dp_status.running) begin
               state_in = ST_EMIT;
            end else if (dp_status.update_ok) begin
               state_in = ST_RATE_START;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_RATE_START: begin
            state_in = ST_RATE_WAIT;
         end
         ST_RATE_WAIT: begin
            if (dp_status.div_done) begin
               state_in = ST_AVG_PREP;
            end
         end
         ST_AVG_PREP: begin
            state_in = ST_AVG_START;
         end
         ST_AVG_START: begin
            state_in = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (dp_status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs per state
   always_comb begin
      req_ready = 1'b0;
      dp_cmd    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            dp_cmd.latch_in = req_valid;
         end
         ST_EVAL: begin
            dp_cmd.do_restart   = dp_status.restart_req;
            dp_cmd.do_first     = !dp_status.restart_req && !dp_status.running;
            dp_cmd.capture_rate = !dp_status.restart_req && dp_status.running &&
                                  dp_status.update_ok;
         end
         ST_RATE_START: begin
            dp_cmd.div_start = 1'b1;
         end
         ST_RATE_WAIT: begin
            dp_cmd.commit_rate = dp_status.div_done;
         end
         ST_AVG_PREP: begin
            dp_cmd.capture_avg = 1'b1;
         end
         ST_AVG_START: begin
            dp_cmd.div_start = 1'b1;
         end
         ST_AVG_WAIT: begin
            dp_cmd.commit_avg = dp_status.div_done;
         end
         ST_EMIT: begin
            dp_cmd.load_rsp = slot_free;
         end
         default: begin
         end
      endcase
   end

   // Response valid
   always_comb begin
      priority if (dp_cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("response raised outside emit");
   a_emit_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && rsp_valid_ff && !rsp_ready |=> (state_ff == ST_EMIT))
      else $error("result left emit while response slot busy");
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while one in flight");
`endif

endmodule

### rtl/throughput_rate_meter_top.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake     | Payload
// req_chan | in        | valid / ready | cmd, total_bytes, now_ms
// rsp_chan | out       | valid / ready | rate_now, rate_changed, rate_average
// csr      | in        | csr_we        | csr_wdata = min_window_ms
//
// Restart, first sample and samples without a new rate: the request is latched, then
// evaluated, then its result is registered. For a new rate the shared divider runs
// twice (rate, then average), with operand prep before and commit after each run.
// One request is in flight at a time; a new one is taken while the last result waits.
// Synchronous active-high reset; rsp_chan stalls hold the result in the output register.
module throughput_rate_meter_top import trm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   trm_req_if.sink                req_chan,
   trm_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [WINDOW_BITS-1:0] csr_wdata
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   trm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   trm_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_cmd          (req_chan.cmd),
      .req_total_bytes  (req_chan.total_bytes),
      .req_now_ms       (req_chan.now_ms),
      .rsp_rate_now     (rsp_chan.rate_now),
      .rsp_rate_changed (rsp_chan.rate_changed),
      .rsp_rate_average (rsp_chan.rate_average)
   );

endmodule
